// File: rtl/line_peak_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Line peak tracker assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINE_PEAK_TRACKER_TOP_MACROS_SVH
`define LINE_PEAK_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LPT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define LPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpt_pkg.sv
// ----------------------------------------------------------------------------
// Line peak tracker package
// Widths, register indexes and beat types shared by the tracker files.
// ----------------------------------------------------------------------------
`default_nettype none

package lpt_pkg;

    // Line store geometry (line length is a power of two)
    localparam int LINE_LEN = 1024;
    localparam int IDX_W    = $clog2(LINE_LEN);
    localparam int SAMPLE_W = 32;

    // Register and result field widths
    localparam int CFG_W     = 10;
    localparam int OUT_IDX_W = 10;
    localparam int FRAC_W    = 16;

    // Neighbour arithmetic: signed, room for index plus/minus one
    localparam int NB_W = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 2;

    // Curvature arithmetic
    localparam int NUM_W  = SAMPLE_W + 1;
    localparam int SUM_W  = SAMPLE_W + 2;
    localparam int AD_W   = SUM_W + 1;
    localparam int DIV_W  = AD_W + 1 + FRAC_W;
    localparam int CNT_W  = $clog2(FRAC_W + 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(FRAC_W);

    // Saturation limits of the fraction
    localparam logic [FRAC_W-1:0] FRAC_POS_MAX = {1'b0, {(FRAC_W-1){1'b1}}};
    localparam logic [FRAC_W-1:0] FRAC_NEG_MAG = {1'b1, {(FRAC_W-1){1'b0}}};

    // Configuration port
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_LINE_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LINE_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_POS = 2'd2;

    localparam logic [CFG_W-1:0] LINE_LOW_RST  = CFG_W'(0);
    localparam logic [CFG_W-1:0] LINE_HIGH_RST = CFG_W'(1023);
    localparam logic [CFG_W-1:0] START_POS_RST = CFG_W'(5);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       sample_last;
    } sample_t;

    typedef struct packed {
        logic        [OUT_IDX_W-1:0] peak_index;
        logic signed [FRAC_W-1:0]    peak_fraction;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/lpt_ram.sv
// ----------------------------------------------------------------------------
// Line peak tracker RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/line_peak_tracker_top.sv
// ----------------------------------------------------------------------------
// Line peak tracker
// Loads a line of samples, hill-climbs to the local peak from the kept index
// and reports the peak index with a parabolic sub-cell offset.
// ----------------------------------------------------------------------------
// Use: samples arrive on the in channel, one beat per line index from 0
// upward; the beat with sample_last set closes the line. Loading takes one
// beat per cycle while in_ready is high. After the last beat in_ready drops
// and the climb starts from the kept peak index (start_position on the first
// line after reset). Each visited index steps through the mid, left, right
// and decide states, as mid, left and right are read one after another
// through the single read port of the line store. The offset divider then
// yields one quotient bit per cycle. One result beat leaves on the out
// channel per line. It waits in an output register; loading of the next
// line goes on meanwhile, and only a finished climb holds while that
// register is still full and out_ready is low. Reset clears the load
// address and the tracking state; the line store is not cleared, so every
// index the climb touches must have been loaded. Registers line_low,
// line_high and start_position sit at 0x0, 0x4 and 0x8.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_peak_tracker_top_macros.svh"

module line_peak_tracker_top
    import lpt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Sample channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sample_t           in_data,
    // Result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output result_t                out_data,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // State codes
    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_RD_MID   = 4'd1;
    localparam logic [3:0] S_RD_LEFT  = 4'd2;
    localparam logic [3:0] S_RD_RIGHT = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_PREP     = 4'd5;
    localparam logic [3:0] S_SETUP    = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    // Control state
    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] load_addr_reg, load_addr_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             started_reg, started_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sat_reg, sat_next;
    logic             zero_reg, zero_next;
    logic [CFG_W-1:0] line_low_reg, line_high_reg, start_pos_reg;

    // Payload state
    logic signed [SAMPLE_W-1:0] mid_reg, mid_next;
    logic signed [SAMPLE_W-1:0] lv_reg, lv_next;
    logic signed [SAMPLE_W-1:0] rv_reg, rv_next;
    logic signed [NUM_W-1:0]    num_reg, num_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       neg_reg, neg_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [DIV_W-1:0]           dv_reg, dv_next;
    logic [FRAC_W-1:0]          q_reg, q_next;
    result_t                    out_data_reg, out_data_next;

    // Line store ports
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_sample;

    // Neighbour indexes
    logic signed [NB_W-1:0] pos_minus, pos_plus, left_raw, right_raw;
    logic [IDX_W-1:0]       nb_left, nb_right;

    // Setup and divider helpers
    logic [NUM_W-1:0] abs_num;
    logic [SUM_W-1:0] abs_sum;
    logic [AD_W-1:0]  abs_den;
    logic             div_ge;
    logic [FRAC_W-1:0] frac_val;

    logic in_fire, cfg_write;

    assign in_fire   = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite;
    assign rd_sample = $signed(ram_rdata);

    // Line store
    lpt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_addr_reg),
        .wdata (in_data.sample_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we = in_fire;

    // Form neighbours, wrapping over the interior of the guards
    always_comb
    begin
        pos_minus = $signed(NB_W'(pos_reg)) - NB_W'(1);
        pos_plus  = $signed(NB_W'(pos_reg)) + NB_W'(1);
        if (pos_minus <= $signed(NB_W'(line_low_reg)))
        begin
            left_raw = $signed(NB_W'(line_high_reg)) - NB_W'(1);
        end
        else
        begin
            left_raw = pos_minus;
        end
        if (pos_plus >= $signed(NB_W'(line_high_reg)))
        begin
            right_raw = $signed(NB_W'(line_low_reg)) + NB_W'(1);
        end
        else
        begin
            right_raw = pos_plus;
        end
        nb_left  = left_raw[IDX_W-1:0];
        nb_right = right_raw[IDX_W-1:0];
    end

    // Select the store read address
    always_comb
    begin
        unique case (state_reg)
            S_RD_LEFT:  ram_raddr = nb_left;
            S_RD_RIGHT: ram_raddr = nb_right;
            default:    ram_raddr = pos_reg;
        endcase
    end

    // Saturate the offset
    always_comb
    begin
        if (zero_reg)
        begin
            frac_val = '0;
        end
        else if (neg_reg)
        begin
            if (sat_reg || (q_reg > FRAC_NEG_MAG))
            begin
                frac_val = FRAC_NEG_MAG;
            end
            else
            begin
                frac_val = FRAC_W'(~q_reg + FRAC_W'(1));
            end
        end
        else if (sat_reg || (q_reg > FRAC_POS_MAX))
        begin
            frac_val = FRAC_POS_MAX;
        end
        else
        begin
            frac_val = q_reg;
        end
    end

    assign abs_num = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign abs_sum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign abs_den = {abs_sum, 1'b0};
    assign div_ge  = (rem_reg >= dv_reg);

    // Sequence load, climb, divide and report
    always_comb
    begin
        state_next     = state_reg;
        load_addr_next = load_addr_reg;
        pos_next       = pos_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        zero_next      = zero_reg;
        mid_next       = mid_reg;
        lv_next        = lv_reg;
        rv_next        = rv_reg;
        num_next       = num_reg;
        sum_next       = sum_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        q_next         = q_reg;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    if (in_data.sample_last)
                    begin
                        load_addr_next = '0;
                        if (!started_reg)
                        begin
                            pos_next = IDX_W'(NB_W'(start_pos_reg));
                        end
                        state_next = S_RD_MID;
                    end
                    else if (load_addr_reg == IDX_W'(LINE_LEN - 1))
                    begin
                        load_addr_next = '0;
                    end
                    else
                    begin
                        load_addr_next = load_addr_reg + IDX_W'(1);
                    end
                end
            end
            S_RD_MID:
            begin
                state_next = S_RD_LEFT;
            end
            S_RD_LEFT:
            begin
                mid_next   = rd_sample;
                state_next = S_RD_RIGHT;
            end
            S_RD_RIGHT:
            begin
                lv_next    = rd_sample;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                rv_next = rd_sample;
                if (rd_sample > mid_reg)
                begin
                    pos_next   = nb_right;
                    state_next = S_RD_MID;
                end
                else if (lv_reg > mid_reg)
                begin
                    pos_next   = nb_left;
                    state_next = S_RD_MID;
                end
                else
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                num_next   = NUM_W'(lv_reg) - NUM_W'(rv_reg);
                sum_next   = SUM_W'(lv_reg) - (SUM_W'(mid_reg) <<< 1) + SUM_W'(rv_reg);
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                neg_next  = num_reg[NUM_W-1] ^ sum_reg[SUM_W-1];
                zero_next = (sum_reg == '0);
                rem_next  = (DIV_W'(abs_num) << FRAC_W) + DIV_W'(abs_den);
                dv_next   = DIV_W'(abs_den) << (FRAC_W + 1);
                q_next    = '0;
                sat_next  = 1'b0;
                cnt_next  = DIV_STEPS;
                state_next = (sum_reg == '0) ? S_FINISH : S_DIV;
            end
            S_DIV:
            begin
                if ((cnt_reg == DIV_STEPS) && div_ge)
                begin
                    sat_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    if (div_ge)
                    begin
                        rem_next = rem_reg - dv_reg;
                    end
                    q_next  = {q_reg[FRAC_W-2:0], div_ge};
                    dv_next = dv_reg >> 1;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.peak_index    = OUT_IDX_W'(NB_W'(pos_reg));
                    out_data_next.peak_fraction = $signed(frac_val);
                    out_valid_next = 1'b1;
                    started_next   = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_addr_reg <= '0;
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            zero_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_addr_reg <= load_addr_next;
            pos_reg       <= pos_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            zero_reg      <= zero_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        mid_reg      <= mid_next;
        lv_reg       <= lv_next;
        rv_reg       <= rv_next;
        num_reg      <= num_next;
        sum_reg      <= sum_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        dv_reg       <= dv_next;
        q_reg        <= q_next;
        out_data_reg <= out_data_next;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_low_reg  <= LINE_LOW_RST;
            line_high_reg <= LINE_HIGH_RST;
            start_pos_reg <= START_POS_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[REG_IDX_W+1:2])
                REG_LINE_LOW:  line_low_reg  <= pwdata[CFG_W-1:0];
                REG_LINE_HIGH: line_high_reg <= pwdata[CFG_W-1:0];
                REG_START_POS: start_pos_reg <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (paddr[REG_IDX_W+1:2])
            REG_LINE_LOW:  prdata = APB_DW'(line_low_reg);
            REG_LINE_HIGH: prdata = APB_DW'(line_high_reg);
            REG_START_POS: prdata = APB_DW'(start_pos_reg);
            default:       prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `LPT_ASSERT_NEXT(a_last_starts_climb, in_fire && in_data.sample_last,
        (load_addr_reg == '0) && (state_reg == S_RD_MID),
        "last beat did not restart loading and start the climb")
    `LPT_ASSERT_NEXT(a_climb_right, (state_reg == S_DECIDE) && (rd_sample > mid_reg),
        pos_reg == $past(nb_right), "climb did not step to the greater right neighbour")
    `LPT_ASSERT_IMPL(a_result_from_finish, $rose(out_valid_reg),
        $past(state_reg) == S_FINISH, "result beat raised outside the finish step")
    `LPT_ASSERT_IMPL(a_div_count_range, state_reg == S_DIV,
        cnt_reg <= DIV_STEPS, "divider step count out of range")

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Line peak tracker testbench
// Streams lines of samples into the tracker and checks each peak index and
// parabolic offset against a behavioural hill climb kept alongside the DUT.
// Directed lines exercise sample extremes, wrap at the guards, flat curvature
// and ties. One overlong line fills the whole store and wraps the load
// address. Random lines follow under changing guard settings, with random
// gaps on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
    import lpt_pkg::*;

    localparam int ITEM_TARGET    = 1550;
    localparam int QUIET_LIMIT    = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int CALM_FROM      = 1120;
    localparam int CALM_TO        = 1320;
    localparam int PRESSURE_PHASE = 2;
    localparam int IDLE_PERCENT   = 29;

    // Guard setting styles
    localparam int BOUNDS_NARROW  = 0;
    localparam int BOUNDS_ANY     = 1;
    localparam int BOUNDS_EXTREME = 2;

    // Line content styles
    localparam int SHAPE_NOISE    = 0;
    localparam int SHAPE_FLAT     = 1;
    localparam int SHAPE_HILL     = 2;
    localparam int SHAPE_RAILS    = 3;

    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    sample_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    result_t out_data;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    // Predictor state
    logic signed [SAMPLE_W-1:0] line_mem [LINE_LEN];
    logic [IDX_W-1:0] load_ptr = '0;
    logic [OUT_IDX_W-1:0] kept_peak = '0;
    bit tracking_live = 1'b0;
    logic [CFG_W-1:0] cfg_low = LINE_LOW_RST;
    logic [CFG_W-1:0] cfg_high = LINE_HIGH_RST;
    logic [CFG_W-1:0] cfg_start = START_POS_RST;

    sample_t sample_backlog [$];
    result_t peak_due [$];
    int queued_total = 0;
    int sample_beats = 0;
    int fault_count = 0;
    int quiet_cycles = 0;
    bit want_hold = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    logic calm;

    assign calm = (sample_beats >= CALM_FROM) && (sample_beats < CALM_TO);

    line_peak_tracker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offset of the parabola vertex in Q1.15, rounded half away from zero
    function automatic logic [FRAC_W-1:0] vertex_offset(longint lv, longint mv, longint rv);
        longint num;
        longint den;
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        bit neg;
        num = lv - rv;
        den = 2 * (lv - 2 * mv + rv);
        if (den == 0)
            return '0;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an * 65536 + ad) / (2 * ad);
        if (neg)
            return (q > 32768) ? FRAC_NEG_MAG : FRAC_W'(-longint'(q));
        return (q > 32767) ? FRAC_POS_MAX : FRAC_W'(q);
    endfunction

    // Store one accepted sample; on the last one climb and queue the peak
    task automatic absorb_sample(sample_t s);
        int pos;
        int pm;
        int pp;
        int im;
        int ip;
        int n;
        longint lv;
        longint mv;
        longint rv;
        bit climbing;
        result_t res;
        line_mem[load_ptr] = s.sample_value;
        load_ptr = load_ptr + 1'b1;
        if (!s.sample_last)
            return;
        load_ptr = '0;
        pos = tracking_live ? int'(kept_peak) : int'(cfg_start);
        climbing = 1'b1;
        lv = 0;
        mv = 0;
        rv = 0;
        for (n = 0; n <= LINE_LEN && climbing; n++)
        begin
            pm = pos - 1;
            pp = pos + 1;
            if (pm <= int'(cfg_low))
                pm = int'(cfg_high) - 1;
            if (pp >= int'(cfg_high))
                pp = int'(cfg_low) + 1;
            im = pm & (LINE_LEN - 1);
            ip = pp & (LINE_LEN - 1);
            mv = line_mem[pos];
            lv = line_mem[im];
            rv = line_mem[ip];
            if (rv > mv)
                pos = ip;
            else if (lv > mv)
                pos = im;
            else
                climbing = 1'b0;
        end
        kept_peak = OUT_IDX_W'(pos);
        tracking_live = 1'b1;
        res.peak_index = OUT_IDX_W'(pos);
        res.peak_fraction = vertex_offset(lv, mv, rv);
        peak_due.push_back(res);
    endtask

    function automatic void log_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    // Sender: hold each beat until taken, then offer the next or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (sample_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT))
            begin
                in_data <= sample_backlog.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (want_hold && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Monitor: predict on each sample beat, check each result beat
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sample_beats <= sample_beats + 1;
                absorb_sample(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (peak_due.size() == 0)
                    log_fault($sformatf("unexpected result: index %0d fraction %0d",
                        out_data.peak_index, out_data.peak_fraction));
                else
                begin
                    want = peak_due.pop_front();
                    if (out_data.peak_index !== want.peak_index
                            || out_data.peak_fraction !== want.peak_fraction)
                        log_fault($sformatf(
                            "peak wrong: expected index %0d fraction %0d, got index %0d fraction %0d",
                            want.peak_index, want.peak_fraction,
                            out_data.peak_index, out_data.peak_fraction));
                end
            end
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Write one register through setup and access cycles, then mirror it
    task automatic program_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LINE_LOW:  cfg_low = value;
            REG_LINE_HIGH: cfg_high = value;
            REG_START_POS: cfg_start = value;
            default: ;
        endcase
    endtask

    task automatic queue_sample(logic signed [SAMPLE_W-1:0] value, bit last);
        sample_t s;
        s.sample_value = value;
        s.sample_last = last;
        sample_backlog.push_back(s);
        queued_total++;
    endtask

    task automatic queue_line(int len, int shape);
        int peak;
        int span;
        int i;
        int step;
        logic signed [SAMPLE_W-1:0] base;
        logic signed [SAMPLE_W-1:0] v;
        peak = $urandom_range(len - 1, 0);
        base = $urandom;
        step = $urandom_range(1000, 1);
        for (i = 0; i < len; i++)
        begin
            span = (i > peak) ? i - peak : peak - i;
            case (shape)
                SHAPE_FLAT: v = $urandom_range(3, 0);
                SHAPE_HILL: v = base - SAMPLE_W'(step * span) + $urandom_range(step / 2, 0);
                SHAPE_RAILS:
                begin
                    case ($urandom_range(3, 0))
                        0: v = S_MIN;
                        1: v = S_MAX;
                        2: v = '0;
                        default: v = '1;
                    endcase
                end
                default: v = $urandom;
            endcase
            queue_sample(v, i == len - 1);
        end
    endtask

    task automatic choose_bounds(int mode);
        int lo;
        int hi;
        case (mode)
            BOUNDS_NARROW:
            begin
                lo = $urandom_range(12, 0);
                hi = lo + $urandom_range(24, 2);
            end
            BOUNDS_ANY:
            begin
                lo = $urandom_range(1023, 0);
                hi = $urandom_range(1023, 0);
            end
            default:
            begin
                lo = $urandom_range(1, 0) * 1023;
                hi = $urandom_range(1, 0) * 1023;
            end
        endcase
        program_reg(REG_LINE_LOW, CFG_W'(lo));
        program_reg(REG_LINE_HIGH, CFG_W'(hi));
        program_reg(REG_START_POS, CFG_W'($urandom_range(1023, 0)));
    endtask

    // Wait until every beat is taken and every peak has come back
    task automatic settle();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || in_valid || peak_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] opening [25];
        int phase;
        int lines;
        int len;
        opening = '{S_MIN, 10, 20, S_MAX, -3,
                    0, S_MIN, S_MAX, S_MIN, 0,
                    7, 7, 7, 7, 7,
                    0, 50, 5, 9, 0,
                    0, 8, 8, 3, 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Short lines over a tiny interior: rails, flat top, wrap, tie
        program_reg(REG_LINE_LOW, CFG_W'(0));
        program_reg(REG_LINE_HIGH, CFG_W'(4));
        program_reg(REG_START_POS, CFG_W'(2));
        @(negedge clk);
        foreach (opening[i])
            queue_sample(opening[i], (i % 5) == 4);
        settle();

        // Overlong line: fill every store entry and wrap the load address
        program_reg(REG_LINE_HIGH, CFG_W'(1023));
        program_reg(REG_START_POS, CFG_W'(1023));
        @(negedge clk);
        queue_line(LINE_LEN + $urandom_range(40, 1), SHAPE_NOISE);
        settle();

        // Random phases under fresh guard settings
        phase = 0;
        while (queued_total < ITEM_TARGET)
        begin
            if (phase == 0)
            begin
                program_reg(REG_LINE_LOW, CFG_W'(1023));
                program_reg(REG_LINE_HIGH, CFG_W'(0));
                program_reg(REG_START_POS, CFG_W'(0));
            end
            else
                choose_bounds((phase == PRESSURE_PHASE) ? BOUNDS_NARROW
                                                        : $urandom_range(BOUNDS_EXTREME,
                                                                         BOUNDS_NARROW));
            @(negedge clk);
            if (phase == PRESSURE_PHASE)
                want_hold = 1'b1;
            lines = (phase == PRESSURE_PHASE) ? 12 : $urandom_range(8, 3);
            repeat (lines)
            begin
                if (phase == PRESSURE_PHASE)
                    len = $urandom_range(6, 3);
                else if ($urandom_range(99) < 80)
                    len = $urandom_range(12, 1);
                else
                    len = $urandom_range(64, 13);
                queue_line(len, $urandom_range(3, 0));
            end
            settle();
            phase++;
        end

        repeat (200) @(posedge clk);
        if (fault_count == 0 && peak_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: line_peak_tracker_top.f
+incdir+rtl
rtl/lpt_pkg.sv
rtl/lpt_ram.sv
rtl/line_peak_tracker_top.sv
verif/tb.sv
